// ----- hdl/h2r_pkg.sv -----
// Package for the integer HSV to RGB converter.
// Holds field widths, sector codes, the sector/ramp struct and divider constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  // Field widths of one pixel beat.
  localparam int unsigned HUE_W  = 9;
  localparam int unsigned CHAN_W = 8;

  // Each hue sector spans this many degrees.
  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned RAMP_W     = 6;
  localparam int unsigned NUM_SECT   = 6;

  // The product (value - floor) * ramp stays below 255 * 60 + 1.
  localparam int unsigned PROD_W = CHAN_W + RAMP_W;

  // Division by 60 as a multiplication by ceil(2^20 / 60) and a shift.
  // The reciprocal overshoots 2^20 / 60 by 44 / 60, which keeps
  // the quotient exact for every product below 23831, well above 255 * 60.
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'(17477);

  // Full-scale channel level.
  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

  // Hue sectors; the last code stands for a hue of 360 degrees or more.
  typedef enum logic [2:0] {
    SECT_RED_YEL  = 3'd0,
    SECT_YEL_GRN  = 3'd1,
    SECT_GRN_CYN  = 3'd2,
    SECT_CYN_BLU  = 3'd3,
    SECT_BLU_MAG  = 3'd4,
    SECT_MAG_RED  = 3'd5,
    SECT_NONE     = 3'd6
  } h2r_sector_e;

  // Sector of a hue and the ramp that drives its interpolated channel.
  typedef struct packed {
    h2r_sector_e             sector;
    logic [RAMP_W-1:0]       ramp;
  } h2r_sect_t;

endpackage

`default_nettype wire

// ----- hdl/h2r_if.sv -----
// Stream interfaces for the HSV to RGB converter: one for pixels in, one for colours out.
// Valid/ready handshake; a beat moves when both are high. Depends on h2r_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface h2r_hsv_if import h2r_pkg::*;;
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [CHAN_W-1:0] saturation;
  logic [CHAN_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

interface h2r_rgb_if import h2r_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- hdl/h2r_sector.sv -----
// Hue sector finder: splits a hue into its 60-degree sector and the ramp of that sector.
// Purely combinational. Depends on h2r_pkg.
`timescale 1ns / 1ps
`default_nettype none

module h2r_sector import h2r_pkg::*; (
  input  wire logic [HUE_W-1:0] hue_i,
  output h2r_sect_t             sect_o
);

  logic [NUM_SECT-1:0] above;
  logic [2:0]          count;
  logic [HUE_W-1:0]    base;
  logic [HUE_W-1:0]    rem;
  logic [RAMP_W-1:0]   rise;
  logic [RAMP_W-1:0]   fall;
  h2r_sector_e         sector;

  // Compare the hue against every sector boundary in parallel.
  always_comb begin
    for (int k = 0; k < NUM_SECT; k++) begin
      above[k] = (hue_i >= HUE_W'((k + 1) * SECTOR_DEG));
    end
  end

  // The boundaries are ordered, so the number of boundaries passed is the sector.
  always_comb begin
    count = '0;
    for (int k = 0; k < NUM_SECT; k++) begin
      count = count + 3'(above[k]);
    end
  end

  // Name the sector and find its starting angle.
  always_comb begin
    unique case (count)
      3'd0: begin sector = SECT_RED_YEL; base = HUE_W'(0 * SECTOR_DEG); end
      3'd1: begin sector = SECT_YEL_GRN; base = HUE_W'(1 * SECTOR_DEG); end
      3'd2: begin sector = SECT_GRN_CYN; base = HUE_W'(2 * SECTOR_DEG); end
      3'd3: begin sector = SECT_CYN_BLU; base = HUE_W'(3 * SECTOR_DEG); end
      3'd4: begin sector = SECT_BLU_MAG; base = HUE_W'(4 * SECTOR_DEG); end
      3'd5: begin sector = SECT_MAG_RED; base = HUE_W'(5 * SECTOR_DEG); end
      default: begin sector = SECT_NONE; base = HUE_W'(NUM_SECT * SECTOR_DEG); end
    endcase
  end

  // Remainder within the sector; the falling ramp counts down from 60.
  assign rem  = hue_i - base;
  assign rise = rem[RAMP_W-1:0];
  assign fall = RAMP_W'(SECTOR_DEG) - rise;

  // Even sectors interpolate upwards, odd sectors downwards.
  always_comb begin
    sect_o.sector = sector;
    unique case (sector)
      SECT_YEL_GRN, SECT_CYN_BLU, SECT_MAG_RED: sect_o.ramp = fall;
      default:                                  sect_o.ramp = rise;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/hsv_to_rgb_integer.sv -----
// Integer HSV to RGB converter, 8 bits per channel, four register stages.
// A pixel beat passes through the stage 1 to 4 registers in order; its colour beat is
// shown on rgb_o from stage 4. Each stage holds its beat only while the next is full.
// Throughput: one pixel per cycle while rgb_o.ready is high.
// Reset: asynchronous, active low; it clears the valid bit of every stage.
// Depends on h2r_pkg, h2r_if (h2r_hsv_if, h2r_rgb_if) and h2r_sector.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_integer import h2r_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  h2r_hsv_if.sink     hsv_i,
  h2r_rgb_if.source   rgb_o
);

  // Stage enables: a stage loads when it is empty or its beat moves on.
  logic en1, en2, en3, en4;

  // Stage 1: sector, ramp, floor level.
  logic              v1_q;
  logic              grey1_q;
  h2r_sect_t         sect1_q;
  logic [CHAN_W-1:0] val1_q;
  logic [CHAN_W-1:0] flo1_q;

  // Stage 2: interpolation product.
  logic              v2_q;
  logic              grey2_q;
  h2r_sector_e       sector2_q;
  logic [CHAN_W-1:0] val2_q;
  logic [CHAN_W-1:0] flo2_q;
  logic [PROD_W-1:0] prod2_q;

  // Stage 3: product divided by 60.
  logic              v3_q;
  logic              grey3_q;
  h2r_sector_e       sector3_q;
  logic [CHAN_W-1:0] val3_q;
  logic [CHAN_W-1:0] flo3_q;
  logic [CHAN_W-1:0] quot3_q;

  // Stage 4: output register.
  logic              v4_q;
  logic [CHAN_W-1:0] red4_q, green4_q, blue4_q;
  logic [CHAN_W-1:0] red4_d, green4_d, blue4_d;

  // Combinational intermediates.
  h2r_sect_t                sect1_d;
  logic [2*CHAN_W-1:0]      flo_prod;
  logic [CHAN_W-1:0]        diff2;
  logic [PROD_W+RECIP_W-1:0] recip_prod;
  logic [CHAN_W-1:0]        blend4;

  assign en4 = !v4_q || rgb_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign hsv_i.ready = en1;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= hsv_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: sector lookup and floor = ((255 - s) * v) >> 8.
  h2r_sector u_sector (
    .hue_i  (hsv_i.hue),
    .sect_o (sect1_d)
  );

  assign flo_prod = (2*CHAN_W)'(CHAN_MAX - hsv_i.saturation) * (2*CHAN_W)'(hsv_i.brightness);

  always_ff @(posedge clk_i) begin
    if (en1 && hsv_i.valid) begin
      grey1_q <= (hsv_i.saturation == '0);
      sect1_q <= sect1_d;
      val1_q  <= hsv_i.brightness;
      flo1_q  <= flo_prod[2*CHAN_W-1:CHAN_W];
    end
  end

  // Stage 2: span between value and floor, scaled by the ramp.
  assign diff2 = val1_q - flo1_q;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      grey2_q   <= grey1_q;
      sector2_q <= sect1_q.sector;
      val2_q    <= val1_q;
      flo2_q    <= flo1_q;
      prod2_q   <= PROD_W'(diff2) * PROD_W'(sect1_q.ramp);
    end
  end

  // Stage 3: divide by 60 through the reciprocal.
  assign recip_prod = (PROD_W+RECIP_W)'(prod2_q) * (PROD_W+RECIP_W)'(RECIP_60);

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      grey3_q   <= grey2_q;
      sector3_q <= sector2_q;
      val3_q    <= val2_q;
      flo3_q    <= flo2_q;
      quot3_q   <= recip_prod[RECIP_SHIFT +: CHAN_W];
    end
  end

  // Stage 4: lift the quotient onto the floor and route the channels.
  assign blend4 = quot3_q + flo3_q;

  always_comb begin
    if (grey3_q) begin
      red4_d   = val3_q;
      green4_d = val3_q;
      blue4_d  = val3_q;
    end else begin
      unique case (sector3_q)
        SECT_RED_YEL: begin red4_d = val3_q; green4_d = blend4; blue4_d = flo3_q; end
        SECT_YEL_GRN: begin red4_d = blend4; green4_d = val3_q; blue4_d = flo3_q; end
        SECT_GRN_CYN: begin red4_d = flo3_q; green4_d = val3_q; blue4_d = blend4; end
        SECT_CYN_BLU: begin red4_d = flo3_q; green4_d = blend4; blue4_d = val3_q; end
        SECT_BLU_MAG: begin red4_d = blend4; green4_d = flo3_q; blue4_d = val3_q; end
        SECT_MAG_RED: begin red4_d = val3_q; green4_d = flo3_q; blue4_d = blend4; end
        // A hue of 360 degrees or more gives black, unless the saturation is zero.
        default:      begin red4_d = '0;     green4_d = '0;     blue4_d = '0;     end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      red4_q   <= red4_d;
      green4_q <= green4_d;
      blue4_q  <= blue4_d;
    end
  end

  assign rgb_o.valid = v4_q;
  assign rgb_o.red   = red4_q;
  assign rgb_o.green = green4_q;
  assign rgb_o.blue  = blue4_q;

endmodule

`default_nettype wire
